@@ hw/rtl/aea_pkg.sv @@
// ============================================================================
// Auto exposure adapter package
// Shared widths, fixed-point constants, configuration and multiplier types,
// and the table of negative fractional powers of two.
// ============================================================================
package aea_pkg;

    localparam int LUM_W     = 17;
    localparam int EXP_W     = 18;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    // Digit-serial multiplier geometry.
    localparam int DIGIT_W    = 8;
    localparam int MUL_A_W    = 25;
    localparam int MUL_B_W    = 24;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int MUL_STEPS  = MUL_B_W / DIGIT_W;
    localparam int MUL_STEP_W = $clog2(MUL_STEPS);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_ENABLE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_EXPOSURE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LEVEL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ADAPT_RATE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CUT_CAP         = 3'd4;

    // Register defaults and substitutes for a written zero.
    localparam logic [CFG_W-1:0] MANUAL_DEFAULT = 16'd4096;
    localparam logic [CFG_W-1:0] TARGET_DEFAULT = 16'd2048;
    localparam logic [CFG_W-1:0] RATE_RESET     = 16'd2097;
    localparam logic [CFG_W-1:0] CAP_RESET      = 16'd3072;
    localparam logic [EXP_W-1:0] LO_FLOOR       = 18'd1024;
    localparam logic [EXP_W-1:0] HI_FLOOR       = 18'd16384;
    localparam logic [EXP_W-1:0] LO_RESET       = 18'd2048;
    localparam logic [EXP_W-1:0] HI_RESET       = 18'd16384;
    localparam logic [EXP_W-1:0] EXPOSURE_RESET = 18'd4096;

    // Luminance limits, Q5.11.
    localparam logic signed [LUM_W-1:0] LUM_VALID_HI = 17'sd40960;
    localparam logic signed [LUM_W-1:0] LUM_VALID_LO = -17'sd40960;
    localparam logic signed [LUM_W-1:0] LUM_DARK_MIN = -17'sd40819;
    localparam logic [LUM_W:0]          SLEW_STEP    = 18'd717;
    localparam logic [CFG_W-1:0]        SMOOTH_Q16   = 16'd13107;

    // Adaptation speeds, Q0.16.
    localparam logic [CFG_W-1:0] SPD_DEFAULT      = 16'd1311;
    localparam logic [CFG_W-1:0] SPD_OFF_STATE_TR = 16'd22938;
    localparam logic [CFG_W-1:0] SPD_OFF_IDLE     = 16'd7864;
    localparam logic [CFG_W-1:0] SPD_CUT          = 16'd32768;
    localparam logic [CFG_W-1:0] SPD_DARKEN_MIN   = 16'd16384;
    localparam logic [CFG_W-1:0] SPD_BRIGHTEN_MIN = 16'd5243;
    localparam logic [CFG_W-1:0] SPD_TRANS_MIN    = 16'd19661;

    // Power-of-two evaluation.
    localparam logic [3:0]         POW_BITS  = 4'd11;
    localparam logic [MUL_A_W-1:0] ONE_Q24   = 25'd16777216;
    localparam logic [MUL_P_W-1:0] ROUND_Q24 = 49'h800000;
    localparam logic [MUL_P_W-1:0] ROUND_Q16 = 49'h8000;

    typedef struct packed {
        logic             auto_enable;
        logic [CFG_W-1:0] manual;
        logic [CFG_W-1:0] target;
        logic [CFG_W-1:0] rate;
        logic [CFG_W-1:0] cut_cap;
        logic [EXP_W-1:0] lo;
        logic [EXP_W-1:0] hi;
    } cfg_t;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic               done;
        logic [MUL_P_W-1:0] product;
    } mul_rsp_t;

    // 2^-(2^idx / 2048) in Q0.24.
    function automatic logic [MUL_B_W-1:0] pow_neg_frac(input logic [3:0] idx);
        logic [MUL_B_W-1:0] val;
        case (idx)
            4'd0:    val = 24'd16771539;
            4'd1:    val = 24'd16765863;
            4'd2:    val = 24'd16754518;
            4'd3:    val = 24'd16731851;
            4'd4:    val = 24'd16686609;
            4'd5:    val = 24'd16596492;
            4'd6:    val = 24'd16417715;
            4'd7:    val = 24'd16065917;
            4'd8:    val = 24'd15384775;
            4'd9:    val = 24'd14107901;
            4'd10:   val = 24'd11863283;
            default: val = 24'd0;
        endcase
        return val;
    endfunction

endpackage

@@ hw/rtl/aea_digit_mult.sv @@
// ============================================================================
// Digit-serial multiplier
// Unsigned multiplier that consumes the multiplier operand one byte per
// cycle, least significant first, and shifts finished product bits down.
// ============================================================================
module aea_digit_mult (
    input  logic              clk,
    input  logic              rst_n,
    input  aea_pkg::mul_req_t req,
    output aea_pkg::mul_rsp_t rsp
);

    logic [aea_pkg::MUL_A_W-1:0]                  a_reg, a_next;
    logic [aea_pkg::MUL_B_W-1:0]                  b_reg, b_next;
    logic [aea_pkg::MUL_P_W-1:0]                  p_reg, p_next;
    logic [aea_pkg::MUL_STEP_W-1:0]               step_reg, step_next;
    logic                                         busy_reg, busy_next;
    logic                                         done_reg, done_next;
    logic [aea_pkg::MUL_A_W+aea_pkg::DIGIT_W-1:0] partial;
    logic [aea_pkg::MUL_A_W+aea_pkg::DIGIT_W-1:0] upper_sum;

    assign partial = {{aea_pkg::DIGIT_W{1'b0}}, a_reg}
                   * {{aea_pkg::MUL_A_W{1'b0}}, b_reg[aea_pkg::DIGIT_W-1:0]};
    assign upper_sum = {{aea_pkg::DIGIT_W{1'b0}},
                        p_reg[aea_pkg::MUL_P_W-1:aea_pkg::MUL_B_W]} + partial;

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        p_next    = p_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            a_next    = req.a;
            b_next    = req.b;
            p_next    = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            p_next = {upper_sum, p_reg[aea_pkg::MUL_B_W-1:aea_pkg::DIGIT_W]};
            b_next = b_reg >> aea_pkg::DIGIT_W;
            if (step_reg == aea_pkg::MUL_STEP_W'(aea_pkg::MUL_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        p_reg <= p_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.product = p_reg;

    // A new product is never requested while one is still being formed.
    assert property (@(posedge clk) disable iff (!rst_n) req.start |-> !busy_reg)
        else $error("multiplier restarted while busy");

endmodule

@@ hw/rtl/aea_cfg_regs.sv @@
// ============================================================================
// Auto exposure configuration registers
// Holds the register file and derives the exposure clamp limits and the
// substitutes for zero-valued settings when a register is written.
// ============================================================================
module aea_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [aea_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [aea_pkg::CFG_W-1:0]        cfg_data,
    output aea_pkg::cfg_t                    cfg
);

    logic                         auto_reg, auto_next;
    logic [aea_pkg::CFG_W-1:0]    manual_reg, manual_next;
    logic [aea_pkg::CFG_W-1:0]    target_reg, target_next;
    logic [aea_pkg::CFG_W-1:0]    rate_reg, rate_next;
    logic [aea_pkg::CFG_W-1:0]    cap_reg, cap_next;
    logic [aea_pkg::EXP_W-1:0]    lo_reg, lo_next;
    logic [aea_pkg::EXP_W-1:0]    hi_reg, hi_next;
    logic [aea_pkg::CFG_W-1:0]    m_new;
    logic [aea_pkg::EXP_W-1:0]    m_half;
    logic [aea_pkg::EXP_W-1:0]    m_quad;

    assign m_new  = (cfg_data == '0) ? aea_pkg::MANUAL_DEFAULT : cfg_data;
    assign m_half = {3'b000, m_new[aea_pkg::CFG_W-1:1]};
    assign m_quad = {m_new, 2'b00};

    always_comb
    begin
        auto_next   = auto_reg;
        manual_next = manual_reg;
        target_next = target_reg;
        rate_next   = rate_reg;
        cap_next    = cap_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                aea_pkg::CFG_AUTO_ENABLE:
                begin
                    auto_next = cfg_data[0];
                end
                aea_pkg::CFG_MANUAL_EXPOSURE:
                begin
                    manual_next = m_new;
                    lo_next     = (m_half > aea_pkg::LO_FLOOR) ? m_half : aea_pkg::LO_FLOOR;
                    hi_next     = (m_quad < aea_pkg::HI_FLOOR) ? aea_pkg::HI_FLOOR : m_quad;
                end
                aea_pkg::CFG_TARGET_LEVEL:
                begin
                    target_next = (cfg_data == '0) ? aea_pkg::TARGET_DEFAULT : cfg_data;
                end
                aea_pkg::CFG_ADAPT_RATE:
                begin
                    rate_next = (cfg_data == '0) ? aea_pkg::SPD_DEFAULT : cfg_data;
                end
                aea_pkg::CFG_CUT_CAP:
                begin
                    cap_next = cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_reg   <= 1'b0;
            manual_reg <= aea_pkg::MANUAL_DEFAULT;
            target_reg <= aea_pkg::TARGET_DEFAULT;
            rate_reg   <= aea_pkg::RATE_RESET;
            cap_reg    <= aea_pkg::CAP_RESET;
            lo_reg     <= aea_pkg::LO_RESET;
            hi_reg     <= aea_pkg::HI_RESET;
        end
        else
        begin
            auto_reg   <= auto_next;
            manual_reg <= manual_next;
            target_reg <= target_next;
            rate_reg   <= rate_next;
            cap_reg    <= cap_next;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
        end
    end

    assign cfg.auto_enable = auto_reg;
    assign cfg.manual      = manual_reg;
    assign cfg.target      = target_reg;
    assign cfg.rate        = rate_reg;
    assign cfg.cut_cap     = cap_reg;
    assign cfg.lo          = lo_reg;
    assign cfg.hi          = hi_reg;

    // The clamp window is never empty.
    assert property (@(posedge clk) disable iff (!rst_n) lo_reg <= hi_reg)
        else $error("exposure clamp window inverted");

endmodule

@@ hw/rtl/auto_exposure_adapter.sv @@
// ============================================================================
// Auto exposure adapter
// Takes one beat per frame and returns one beat with the adapted exposure
// (Q6.12), the filtered log2 luminance (Q5.11) and the history flag. An item
// with automatic adaptation off goes from preparation to the result
// register without using the multiplier. With adaptation on, every multiply
// runs on one shared multiplier that takes a byte of its operand per cycle,
// and the power of two of the target uses one multiply per set bit of the
// 11-bit fraction of the filtered luminance, so that fraction sets how long
// an item takes. A new beat is taken as soon as the previous result has
// been placed in the output register, even while that result is still
// waiting to be taken.
// ============================================================================
module auto_exposure_adapter (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [aea_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [aea_pkg::CFG_W-1:0]          cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [aea_pkg::LUM_W-1:0]   log_luminance,
    input  logic                               luminance_present,
    input  logic                               scene_active,
    input  logic                               state_transition,
    input  logic                               history_reset,
    input  logic                               hard_reset,
    input  logic                               scene_cut,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [aea_pkg::EXP_W-1:0]          exposure,
    output logic signed [aea_pkg::LUM_W-1:0]   filtered_log_luminance,
    output logic                               luminance_held
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_PREP   = 4'd1;
    localparam logic [3:0] ST_SMOOTH = 4'd2;
    localparam logic [3:0] ST_FSET   = 4'd3;
    localparam logic [3:0] ST_POW    = 4'd4;
    localparam logic [3:0] ST_POWM   = 4'd5;
    localparam logic [3:0] ST_TGT    = 4'd6;
    localparam logic [3:0] ST_RULES  = 4'd7;
    localparam logic [3:0] ST_STEP   = 4'd8;
    localparam logic [3:0] ST_OUT    = 4'd9;

    aea_pkg::cfg_t     cfg;
    aea_pkg::mul_req_t mul_req;
    aea_pkg::mul_rsp_t mul_rsp;

    logic [3:0]                        state_reg, state_next;
    logic signed [aea_pkg::LUM_W-1:0]  lum_reg, lum_next;
    logic                              present_reg, present_next;
    logic                              active_reg, active_next;
    logic                              trans_reg, trans_next;
    logic                              hist_reg, hist_next;
    logic                              hard_reg, hard_next;
    logic                              cut_reg, cut_next;
    logic [aea_pkg::EXP_W-1:0]         adapted_reg, adapted_next;
    logic signed [aea_pkg::LUM_W-1:0]  filt_reg, filt_next;
    logic                              hv_reg, hv_next;
    logic [aea_pkg::CFG_W-1:0]         speed_reg, speed_next;
    logic [aea_pkg::EXP_W-1:0]         target_reg, target_next;
    logic signed [aea_pkg::LUM_W-1:0]  f_reg, f_next;
    logic                              d_neg_reg, d_neg_next;
    logic [aea_pkg::MUL_A_W-1:0]       acc_reg, acc_next;
    logic [10:0]                       frac_reg, frac_next;
    logic [3:0]                        bit_reg, bit_next;
    logic [5:0]                        shm1_reg, shm1_next;
    logic                              step_neg_reg, step_neg_next;
    logic                              out_valid_reg, out_valid_next;
    logic [aea_pkg::EXP_W-1:0]         exposure_reg, exposure_next;
    logic signed [aea_pkg::LUM_W-1:0]  filt_out_reg, filt_out_next;
    logic                              held_reg, held_next;

    logic [aea_pkg::EXP_W-1:0]         m_ext;
    logic signed [aea_pkg::LUM_W-1:0]  filt_eff;
    logic                              hv_eff;
    logic                              sample_ok;
    logic signed [aea_pkg::LUM_W:0]    d_full;
    logic [aea_pkg::LUM_W:0]           d_abs;
    logic [9:0]                        d_mag;
    logic [aea_pkg::MUL_P_W-1:0]       smooth_sum;
    logic signed [aea_pkg::LUM_W-1:0]  smooth_r;
    logic signed [aea_pkg::LUM_W-1:0]  f_smooth;
    logic [aea_pkg::LUM_W-1:0]         f_u;
    logic [aea_pkg::MUL_P_W-1:0]       pow_sum;
    logic [40:0]                       v_shifted;
    logic [41:0]                       t_sum;
    logic [40:0]                       t_raw;
    logic [aea_pkg::EXP_W-1:0]         tgt_clamped;
    logic [aea_pkg::CFG_W-1:0]         speed_w;
    logic [aea_pkg::EXP_W-1:0]         target_w;
    logic [19:0]                       a3;
    logic [19:0]                       t4;
    logic [19:0]                       t2;
    logic signed [aea_pkg::EXP_W:0]    diff;
    logic [aea_pkg::EXP_W:0]           diff_mag;
    logic [aea_pkg::MUL_P_W-1:0]       step_sum;
    logic [aea_pkg::EXP_W:0]           delta;
    logic signed [19:0]                next_s;
    logic [aea_pkg::EXP_W-1:0]         adapted_new;

    aea_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    aea_digit_mult u_mult (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    // Frame preparation: history reset view and slew-limited difference.
    assign m_ext     = {2'b00, cfg.manual};
    assign filt_eff  = hist_reg ? '0 : filt_reg;
    assign hv_eff    = hv_reg & ~hist_reg;
    assign sample_ok = present_reg && (lum_reg > aea_pkg::LUM_VALID_LO)
                       && (lum_reg < aea_pkg::LUM_VALID_HI);
    assign d_full    = {lum_reg[aea_pkg::LUM_W-1], lum_reg}
                     - {filt_eff[aea_pkg::LUM_W-1], filt_eff};
    assign d_abs     = d_full[aea_pkg::LUM_W] ? $unsigned(-d_full) : $unsigned(d_full);
    assign d_mag     = (d_abs > aea_pkg::SLEW_STEP) ? aea_pkg::SLEW_STEP[9:0] : d_abs[9:0];

    // Smoothing result, rounded half away from zero.
    assign smooth_sum = mul_rsp.product + aea_pkg::ROUND_Q16;
    assign smooth_r   = $signed({7'b0000000, smooth_sum[25:16]});
    assign f_smooth   = d_neg_reg ? (filt_reg - smooth_r) : (filt_reg + smooth_r);
    assign f_u        = {~f_reg[aea_pkg::LUM_W-1], f_reg[aea_pkg::LUM_W-2:0]};

    // Power-of-two accumulation and target scaling.
    assign pow_sum     = mul_rsp.product + aea_pkg::ROUND_Q24;
    assign v_shifted   = mul_rsp.product[40:0] >> shm1_reg;
    assign t_sum       = {1'b0, v_shifted} + 42'd1;
    assign t_raw       = t_sum[41:1];
    assign tgt_clamped = (t_raw < {23'd0, cfg.lo}) ? cfg.lo :
                         (t_raw > {23'd0, cfg.hi}) ? cfg.hi : t_raw[aea_pkg::EXP_W-1:0];

    // Cut cap and speed rules.
    assign a3 = {2'b00, adapted_reg} + {1'b0, adapted_reg, 1'b0};
    assign t4 = {target_w, 2'b00};
    assign t2 = {1'b0, target_w, 1'b0};

    always_comb
    begin
        speed_w  = speed_reg;
        target_w = target_reg;
        if (cut_reg)
        begin
            speed_w = aea_pkg::SPD_CUT;
            if ((cfg.cut_cap != '0) && (target_reg > {2'b00, cfg.cut_cap}))
            begin
                target_w = {2'b00, cfg.cut_cap};
            end
        end
        if (!hard_reg && (adapted_reg != '0))
        begin
            if (t4 < a3)
            begin
                if (speed_w < aea_pkg::SPD_DARKEN_MIN)
                begin
                    speed_w = aea_pkg::SPD_DARKEN_MIN;
                end
            end
            else if (t2 > a3)
            begin
                if (speed_w < aea_pkg::SPD_BRIGHTEN_MIN)
                begin
                    speed_w = aea_pkg::SPD_BRIGHTEN_MIN;
                end
            end
        end
        if (trans_reg && (speed_w < aea_pkg::SPD_TRANS_MIN))
        begin
            speed_w = aea_pkg::SPD_TRANS_MIN;
        end
    end

    assign diff     = $signed({1'b0, target_w}) - $signed({1'b0, adapted_reg});
    assign diff_mag = diff[aea_pkg::EXP_W] ? $unsigned(-diff) : $unsigned(diff);

    // Exposure step and final clamp.
    assign step_sum    = mul_rsp.product + aea_pkg::ROUND_Q16;
    assign delta       = step_sum[34:16];
    assign next_s      = step_neg_reg
                       ? ($signed({2'b00, adapted_reg}) - $signed({1'b0, delta}))
                       : ($signed({2'b00, adapted_reg}) + $signed({1'b0, delta}));
    assign adapted_new = (next_s < $signed({2'b00, cfg.lo})) ? cfg.lo :
                         (next_s > $signed({2'b00, cfg.hi})) ? cfg.hi :
                         next_s[aea_pkg::EXP_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        lum_next       = lum_reg;
        present_next   = present_reg;
        active_next    = active_reg;
        trans_next     = trans_reg;
        hist_next      = hist_reg;
        hard_next      = hard_reg;
        cut_next       = cut_reg;
        adapted_next   = adapted_reg;
        filt_next      = filt_reg;
        hv_next        = hv_reg;
        speed_next     = speed_reg;
        target_next    = target_reg;
        f_next         = f_reg;
        d_neg_next     = d_neg_reg;
        acc_next       = acc_reg;
        frac_next      = frac_reg;
        bit_next       = bit_reg;
        shm1_next      = shm1_reg;
        step_neg_next  = step_neg_reg;
        out_valid_next = out_valid_reg && !out_ready;
        exposure_next  = exposure_reg;
        filt_out_next  = filt_out_reg;
        held_next      = held_reg;
        mul_req        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    lum_next     = log_luminance;
                    present_next = luminance_present;
                    active_next  = scene_active;
                    trans_next   = state_transition;
                    hist_next    = history_reset;
                    hard_next    = hard_reset;
                    cut_next     = scene_cut;
                    state_next   = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (hist_reg)
                begin
                    adapted_next = m_ext;
                    hv_next      = 1'b0;
                    filt_next    = '0;
                end
                target_next = m_ext;
                speed_next  = cfg.rate;
                if (!cfg.auto_enable)
                begin
                    state_next = ST_OUT;
                end
                else if (!active_reg)
                begin
                    hv_next    = 1'b0;
                    filt_next  = '0;
                    speed_next = trans_reg ? aea_pkg::SPD_OFF_STATE_TR : aea_pkg::SPD_OFF_IDLE;
                    state_next = ST_RULES;
                end
                else if (hard_reg || cut_reg)
                begin
                    hv_next    = 1'b0;
                    filt_next  = '0;
                    state_next = ST_RULES;
                end
                else if (!sample_ok)
                begin
                    state_next = ST_RULES;
                end
                else if (hv_eff)
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = {15'd0, d_mag};
                    mul_req.b     = {8'd0, aea_pkg::SMOOTH_Q16};
                    d_neg_next    = d_full[aea_pkg::LUM_W];
                    state_next    = ST_SMOOTH;
                end
                else
                begin
                    f_next     = lum_reg;
                    state_next = ST_FSET;
                end
            end
            ST_SMOOTH:
            begin
                if (mul_rsp.done)
                begin
                    f_next     = f_smooth;
                    state_next = ST_FSET;
                end
            end
            ST_FSET:
            begin
                filt_next = f_reg;
                hv_next   = 1'b1;
                if (f_reg >= aea_pkg::LUM_DARK_MIN)
                begin
                    acc_next   = aea_pkg::ONE_Q24;
                    frac_next  = f_u[10:0];
                    bit_next   = '0;
                    shm1_next  = f_u[16:11] - 6'd9;
                    state_next = ST_POW;
                end
                else
                begin
                    state_next = ST_RULES;
                end
            end
            ST_POW:
            begin
                if (bit_reg == aea_pkg::POW_BITS)
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = acc_reg;
                    mul_req.b     = {8'd0, cfg.target};
                    state_next    = ST_TGT;
                end
                else if (frac_reg[0])
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = acc_reg;
                    mul_req.b     = aea_pkg::pow_neg_frac(bit_reg);
                    state_next    = ST_POWM;
                end
                else
                begin
                    frac_next = frac_reg >> 1;
                    bit_next  = bit_reg + 4'd1;
                end
            end
            ST_POWM:
            begin
                if (mul_rsp.done)
                begin
                    acc_next   = pow_sum[aea_pkg::MUL_P_W-1:24];
                    frac_next  = frac_reg >> 1;
                    bit_next   = bit_reg + 4'd1;
                    state_next = ST_POW;
                end
            end
            ST_TGT:
            begin
                if (mul_rsp.done)
                begin
                    target_next = tgt_clamped;
                    state_next  = ST_RULES;
                end
            end
            ST_RULES:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = {6'd0, diff_mag};
                mul_req.b     = {8'd0, speed_w};
                step_neg_next = diff[aea_pkg::EXP_W];
                state_next    = ST_STEP;
            end
            ST_STEP:
            begin
                if (mul_rsp.done)
                begin
                    adapted_next = adapted_new;
                    state_next   = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    exposure_next  = adapted_reg;
                    filt_out_next  = filt_reg;
                    held_next      = hv_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            adapted_reg   <= aea_pkg::EXPOSURE_RESET;
            filt_reg      <= '0;
            hv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            adapted_reg   <= adapted_next;
            filt_reg      <= filt_next;
            hv_reg        <= hv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lum_reg      <= lum_next;
        present_reg  <= present_next;
        active_reg   <= active_next;
        trans_reg    <= trans_next;
        hist_reg     <= hist_next;
        hard_reg     <= hard_next;
        cut_reg      <= cut_next;
        speed_reg    <= speed_next;
        target_reg   <= target_next;
        f_reg        <= f_next;
        d_neg_reg    <= d_neg_next;
        acc_reg      <= acc_next;
        frac_reg     <= frac_next;
        bit_reg      <= bit_next;
        shm1_reg     <= shm1_next;
        step_neg_reg <= step_neg_next;
        exposure_reg <= exposure_next;
        filt_out_reg <= filt_out_next;
        held_reg     <= held_next;
    end

    assign in_ready               = (state_reg == ST_IDLE);
    assign out_valid              = out_valid_reg;
    assign exposure               = exposure_reg;
    assign filtered_log_luminance = filt_out_reg;
    assign luminance_held         = held_reg;

    // An accepted beat always starts frame preparation.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_PREP))
        else $error("accepted beat did not start processing");

    // Multiplier results only arrive while the sequencer waits for one.
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done |-> (state_reg == ST_SMOOTH || state_reg == ST_POWM
                          || state_reg == ST_TGT || state_reg == ST_STEP))
        else $error("multiplier result arrived in an unexpected state");

    // An adaptation step always lands inside the clamp window.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP && mul_rsp.done)
        |=> (adapted_reg >= $past(cfg.lo) && adapted_reg <= $past(cfg.hi)))
        else $error("adapted exposure outside clamp window");

    // Filter history that is not valid is always cleared to zero.
    assert property (@(posedge clk) disable iff (!rst_n) !hv_reg |-> (filt_reg == '0))
        else $error("filtered luminance kept without valid history");

endmodule
